// ----- design/fwrm_pkg.sv -----
// Shared types and constants for the running-minimum FIFO.
package fwrm_pkg;

  localparam int unsigned QueueDepthDefault = 256;
  localparam int unsigned DataW = 32;

  typedef enum logic [1:0] {
    OP_QUERY   = 2'd0,
    OP_ENQUEUE = 2'd1,
    OP_DEQUEUE = 2'd2,
    OP_CLEAR   = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_EN_CMP,
    S_EN_WR,
    S_DQ_CMP,
    S_READ,
    S_LOAD
  } state_e;

  typedef struct packed {
    logic    latch;
    logic    clear;
    logic    enq_write;
    logic    rd_heads;
    logic    rd_back;
    logic    drop_back;
    logic    push_min;
    logic    dq_commit;
    logic    load_out;
    logic    status_we;
    status_e status;
  } dp_cmd_t;

  typedef struct packed {
    opcode_e op;
    logic    cnt_zero;
    logic    cnt_full;
    logic    min_nonempty;
    logic    min_multi;
    logic    back_gt;
  } dp_stat_t;

endpackage

// ----- design/fwrm_ctrl.sv -----
// Sequencing state machine for the running-minimum FIFO.
module fwrm_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  fwrm_pkg::dp_stat_t stat_i,
  output fwrm_pkg::dp_cmd_t  cmd_o
);

  fwrm_pkg::state_e state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fwrm_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      fwrm_pkg::S_IDLE: begin
        if (in_valid_i) state_d = fwrm_pkg::S_EXEC;
      end
      fwrm_pkg::S_EXEC: begin
        case (stat_i.op)
          fwrm_pkg::OP_ENQUEUE: begin
            if (stat_i.cnt_full) state_d = fwrm_pkg::S_READ;
            else if (stat_i.min_nonempty) state_d = fwrm_pkg::S_EN_CMP;
            else state_d = fwrm_pkg::S_EN_WR;
          end
          fwrm_pkg::OP_DEQUEUE: begin
            if (stat_i.cnt_zero) state_d = fwrm_pkg::S_READ;
            else state_d = fwrm_pkg::S_DQ_CMP;
          end
          default: state_d = fwrm_pkg::S_READ;
        endcase
      end
      fwrm_pkg::S_EN_CMP: begin
        if (!(stat_i.back_gt && stat_i.min_multi)) state_d = fwrm_pkg::S_EN_WR;
      end
      fwrm_pkg::S_EN_WR:  state_d = fwrm_pkg::S_READ;
      fwrm_pkg::S_DQ_CMP: state_d = fwrm_pkg::S_READ;
      fwrm_pkg::S_READ:   state_d = fwrm_pkg::S_LOAD;
      fwrm_pkg::S_LOAD: begin
        if (out_free) state_d = fwrm_pkg::S_IDLE;
      end
      default: state_d = fwrm_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    cmd_o.status = fwrm_pkg::ST_OK;
    in_stall_o  = 1'b1;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      fwrm_pkg::S_IDLE: begin
        in_stall_o  = 1'b0;
        cmd_o.latch = in_valid_i;
      end
      fwrm_pkg::S_EXEC: begin
        case (stat_i.op)
          fwrm_pkg::OP_ENQUEUE: begin
            if (stat_i.cnt_full) begin
              cmd_o.status_we = 1'b1;
              cmd_o.status    = fwrm_pkg::ST_FULL;
            end else begin
              cmd_o.enq_write = 1'b1;
              cmd_o.rd_back   = stat_i.min_nonempty;
            end
          end
          fwrm_pkg::OP_DEQUEUE: begin
            if (stat_i.cnt_zero) begin
              cmd_o.status_we = 1'b1;
              cmd_o.status    = fwrm_pkg::ST_EMPTY;
            end else begin
              cmd_o.rd_heads = 1'b1;
            end
          end
          fwrm_pkg::OP_CLEAR: cmd_o.clear = 1'b1;
          default: ;
        endcase
      end
      fwrm_pkg::S_EN_CMP: begin
        cmd_o.drop_back = stat_i.back_gt;
        cmd_o.rd_back   = stat_i.back_gt && stat_i.min_multi;
      end
      fwrm_pkg::S_EN_WR:  cmd_o.push_min  = 1'b1;
      fwrm_pkg::S_DQ_CMP: cmd_o.dq_commit = 1'b1;
      fwrm_pkg::S_READ:   cmd_o.rd_heads  = 1'b1;
      fwrm_pkg::S_LOAD: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- design/fwrm_datapath.sv -----
// Rings, pointers, compares and result register of the running-minimum FIFO.
module fwrm_datapath #(
  parameter int unsigned QUEUE_DEPTH = fwrm_pkg::QueueDepthDefault,
  localparam int unsigned IdxW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [1:0]                        opcode_i,
  input  logic signed [fwrm_pkg::DataW-1:0] value_i,
  input  fwrm_pkg::dp_cmd_t                 cmd_i,
  output fwrm_pkg::dp_stat_t                stat_o,
  output logic [1:0]                        status_o,
  output logic signed [fwrm_pkg::DataW-1:0] dequeued_value_o,
  output logic [CntW-1:0]                   count_o,
  output logic signed [fwrm_pkg::DataW-1:0] front_value_o,
  output logic signed [fwrm_pkg::DataW-1:0] min_value_o,
  output logic                              is_empty_o
);

  localparam int unsigned DW = fwrm_pkg::DataW;
  localparam logic [CntW:0]   DepthWide = (CntW + 1)'(QUEUE_DEPTH);
  localparam logic [CntW-1:0] DepthCnt  = CntW'(QUEUE_DEPTH);
  localparam logic [CntW-1:0] One       = CntW'(1);

  function automatic logic [IdxW-1:0] ring_pos(input logic [IdxW-1:0] head,
                                               input logic [CntW-1:0] off);
    logic [CntW:0] s;
    s = (CntW + 1)'(head) + {1'b0, off};
    if (s >= DepthWide) s = s - DepthWide;
    return s[IdxW-1:0];
  endfunction

  logic [DW-1:0] value_mem [QUEUE_DEPTH];
  logic [DW-1:0] min_mem   [QUEUE_DEPTH];

  logic [IdxW-1:0] value_head_q, min_head_q;
  logic [CntW-1:0] value_count_q, min_count_q;
  logic [1:0]      op_q;
  logic signed [DW-1:0] value_q;
  logic [DW-1:0] vrd_q, mrd_q;
  fwrm_pkg::status_e status_q;
  logic [DW-1:0] dequeued_q;

  logic [1:0]      res_status_q;
  logic [DW-1:0]   res_deq_q, res_front_q, res_min_q;
  logic [CntW-1:0] res_count_q;
  logic            res_empty_q;

  logic [IdxW-1:0] back_addr, min_rd_addr, tail_addr, push_addr;
  logic            head_eq;

  assign back_addr   = ring_pos(min_head_q, min_count_q - One - CntW'(cmd_i.drop_back));
  assign min_rd_addr = cmd_i.rd_back ? back_addr : min_head_q;
  assign tail_addr   = ring_pos(value_head_q, value_count_q);
  assign push_addr   = ring_pos(min_head_q, min_count_q);
  assign head_eq     = (vrd_q == mrd_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.enq_write) value_mem[tail_addr] <= value_q;
    if (cmd_i.rd_heads) vrd_q <= value_mem[value_head_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push_min && (min_count_q < DepthCnt)) min_mem[push_addr] <= value_q;
    if (cmd_i.rd_heads || cmd_i.rd_back) mrd_q <= min_mem[min_rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      value_head_q  <= '0;
      value_count_q <= '0;
      min_head_q    <= '0;
      min_count_q   <= '0;
    end else if (cmd_i.clear) begin
      value_head_q  <= '0;
      value_count_q <= '0;
      min_head_q    <= '0;
      min_count_q   <= '0;
    end else begin
      if (cmd_i.enq_write) value_count_q <= value_count_q + One;
      if (cmd_i.drop_back) min_count_q <= min_count_q - One;
      if (cmd_i.push_min && (min_count_q < DepthCnt)) min_count_q <= min_count_q + One;
      if (cmd_i.dq_commit) begin
        value_head_q  <= ring_pos(value_head_q, One);
        value_count_q <= value_count_q - One;
        if ((min_count_q != '0) && head_eq) begin
          min_head_q  <= ring_pos(min_head_q, One);
          min_count_q <= min_count_q - One;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q       <= opcode_i;
      value_q    <= value_i;
      status_q   <= fwrm_pkg::ST_OK;
      dequeued_q <= '0;
    end else begin
      if (cmd_i.status_we) status_q <= cmd_i.status;
      if (cmd_i.dq_commit) dequeued_q <= vrd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      res_status_q <= status_q;
      res_deq_q    <= dequeued_q;
      res_count_q  <= value_count_q;
      res_empty_q  <= (value_count_q == '0);
      res_front_q  <= (value_count_q == '0) ? '0 : vrd_q;
      res_min_q    <= ((value_count_q == '0) || (min_count_q == '0)) ? '0 : mrd_q;
    end
  end

  assign stat_o.op           = fwrm_pkg::opcode_e'(op_q);
  assign stat_o.cnt_zero     = (value_count_q == '0);
  assign stat_o.cnt_full     = (value_count_q >= DepthCnt);
  assign stat_o.min_nonempty = (min_count_q != '0);
  assign stat_o.min_multi    = (min_count_q > One);
  assign stat_o.back_gt      = ($signed(mrd_q) > value_q);

  assign status_o         = res_status_q;
  assign dequeued_value_o = res_deq_q;
  assign count_o          = res_count_q;
  assign front_value_o    = res_front_q;
  assign min_value_o      = res_min_q;
  assign is_empty_o       = res_empty_q;

endmodule

// ----- design/fifo_with_running_minimum_core.sv -----
// Top level of the FIFO with running minimum.
// A signed FIFO that reports its oldest and smallest values with every item. Each item
// returns one result after the operation. An enqueue compares the new value against the
// back of the minimum ring and drops each larger entry there, one read of the minimum
// memory per compare, before it pushes the new value. A new item is taken once the
// previous one has reached the output register, even while that result is still stalled.
module fifo_with_running_minimum_core #(
  parameter int unsigned QUEUE_DEPTH = fwrm_pkg::QueueDepthDefault,
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [1:0]                        opcode_i,
  input  logic signed [fwrm_pkg::DataW-1:0] value_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [1:0]                        status_o,
  output logic signed [fwrm_pkg::DataW-1:0] dequeued_value_o,
  output logic [CntW-1:0]                   count_o,
  output logic signed [fwrm_pkg::DataW-1:0] front_value_o,
  output logic signed [fwrm_pkg::DataW-1:0] min_value_o,
  output logic                              is_empty_o
);

  fwrm_pkg::dp_cmd_t  cmd;
  fwrm_pkg::dp_stat_t stat;

  fwrm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  fwrm_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .opcode_i         (opcode_i),
    .value_i          (value_i),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .status_o         (status_o),
    .dequeued_value_o (dequeued_value_o),
    .count_o          (count_o),
    .front_value_o    (front_value_o),
    .min_value_o      (min_value_o),
    .is_empty_o       (is_empty_o)
  );

endmodule

// ----- design/fwrm_checker.sv -----
// Port-level checks for the running-minimum FIFO and their binding.
module fwrm_checker #(
  parameter int unsigned QUEUE_DEPTH = fwrm_pkg::QueueDepthDefault,
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1)
) (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic [1:0]                        status_o,
  input logic signed [fwrm_pkg::DataW-1:0] dequeued_value_o,
  input logic [CntW-1:0]                   count_o,
  input logic signed [fwrm_pkg::DataW-1:0] front_value_o,
  input logic signed [fwrm_pkg::DataW-1:0] min_value_o,
  input logic                              is_empty_o
);

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(count_o) && $stable(status_o))
    else $error("stalled item changed");

  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (is_empty_o == (count_o == '0)))
    else $error("empty flag disagrees with count");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_empty_o |-> (front_value_o == '0) && (min_value_o == '0))
    else $error("empty queue reports values");

  a_deq_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == fwrm_pkg::ST_EMPTY) |-> is_empty_o && (dequeued_value_o == '0))
    else $error("dequeue error with data");

  a_min_le_front: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !is_empty_o |-> (min_value_o <= front_value_o) &&
    (count_o <= CntW'(QUEUE_DEPTH)))
    else $error("minimum above front or count out of range");

endmodule

bind fifo_with_running_minimum_core fwrm_checker #(
  .QUEUE_DEPTH (QUEUE_DEPTH)
) u_fwrm_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .status_o         (status_o),
  .dequeued_value_o (dequeued_value_o),
  .count_o          (count_o),
  .front_value_o    (front_value_o),
  .min_value_o      (min_value_o),
  .is_empty_o       (is_empty_o)
);
